// File: sv/ffba_pkg.sv
`default_nettype none

package ffba_pkg;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_INVALID  = 2'd1;
	localparam logic [1:0] ST_NO_SPACE = 2'd2;

	typedef struct packed {
		logic used;
		logic first;
		logic cont;
	} bank_mark_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ALLOC_SCAN,
		S_ALLOC_MARK,
		S_FREE_FIND,
		S_FREE_WALK,
		S_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic       load;
		logic       step;
		logic       jump;
		logic       scan;
		logic       we;
		logic       wr_mark;
		logic       set_res;
		logic [1:0] res_code;
		logic       res_addr;
		logic       push;
	} dp_cmd_t;

	typedef struct packed {
		logic is_free;
		logic zero_bytes;
		logic out_of_range;
		logic used;
		logic first;
		logic cont;
		logic alloc_hit;
		logic find_hit;
		logic last_idx;
		logic at_end;
		logic out_full;
	} dp_stat_t;

endpackage

`default_nettype wire

// File: sv/ffba_ram.sv
`default_nettype none

module ffba_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 128
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: sv/ffba_ctrl.sv
`default_nettype none

module ffba_ctrl import ffba_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = (state_q != S_IDLE);
		case (state_q)
			S_CLEAR: begin
				cmd.we = 1'b1;
				if (stat.last_idx) begin
					state_d = S_IDLE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (stat.is_free) begin
						if (stat.out_of_range) begin
							cmd.set_res  = 1'b1;
							cmd.res_code = ST_INVALID;
							state_d      = S_DONE;
						end else begin
							state_d = S_FREE_FIND;
						end
					end else if (stat.zero_bytes) begin
						cmd.set_res  = 1'b1;
						cmd.res_code = ST_NO_SPACE;
						state_d      = S_DONE;
					end else begin
						state_d = S_ALLOC_SCAN;
					end
				end
			end
			S_ALLOC_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.alloc_hit) begin
					cmd.jump = 1'b1;
					state_d  = S_ALLOC_MARK;
				end else if (stat.last_idx) begin
					cmd.set_res  = 1'b1;
					cmd.res_code = ST_NO_SPACE;
					state_d      = S_DONE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_ALLOC_MARK: begin
				cmd.we      = 1'b1;
				cmd.wr_mark = 1'b1;
				if (stat.at_end) begin
					cmd.set_res  = 1'b1;
					cmd.res_code = ST_OK;
					cmd.res_addr = 1'b1;
					state_d      = S_DONE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_FREE_FIND: begin
				if (stat.find_hit) begin
					if (stat.used && stat.first) begin
						state_d = S_FREE_WALK;
					end else begin
						cmd.set_res  = 1'b1;
						cmd.res_code = ST_INVALID;
						state_d      = S_DONE;
					end
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_FREE_WALK: begin
				cmd.we = 1'b1;
				if (stat.cont && !stat.last_idx) begin
					cmd.step = 1'b1;
				end else begin
					cmd.set_res  = 1'b1;
					cmd.res_code = ST_OK;
					state_d      = S_DONE;
				end
			end
			S_DONE: begin
				if (!stat.out_full) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: sv/ffba_dp.sv
`default_nettype none

module ffba_dp import ffba_pkg::*; #(
	parameter int BANK_BYTES = 64,
	parameter int NUM_BANKS  = 128
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [31:0]           cfg_wr_data,
	input  wire logic                  opcode,
	input  wire logic [31:0]           request_bytes,
	input  wire logic [31:0]           free_address,
	input  wire logic                  out_stall,
	input  wire dp_cmd_t               cmd,
	output dp_stat_t                   stat,
	output logic                       out_valid,
	output logic [31:0]                returned_address,
	output logic [1:0]                 status,
	output logic                       ram_we,
	output logic [((NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1)-1:0] ram_waddr,
	output bank_mark_t                 ram_wdata,
	output logic [((NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1)-1:0] ram_raddr,
	input  wire bank_mark_t            ram_rdata
);

	localparam int IDX_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
	localparam int OFF_W = $clog2(NUM_BANKS * BANK_BYTES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(NUM_BANKS - 1);
	localparam logic [OFF_W-1:0] BANK_OFF   = OFF_W'(BANK_BYTES);
	localparam logic [31:0]      HEAP_BYTES = 32'(NUM_BANKS * BANK_BYTES);

	logic [31:0]      heap_base_q;
	logic [31:0]      bytes_q;
	logic [31:0]      offset_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] idx_d;
	logic [IDX_W-1:0] start_idx_q;
	logic [IDX_W-1:0] end_idx_q;
	logic [OFF_W-1:0] cur_off_q;
	logic [OFF_W-1:0] run_bytes_q;
	logic [OFF_W-1:0] start_off_q;
	logic [OFF_W-1:0] run_next;
	logic [OFF_W-1:0] cur_next;
	logic [31:0]      off_now;
	logic [31:0]      res_addr_q;
	logic [1:0]       res_status_q;
	logic             out_valid_q;
	logic [31:0]      out_addr_q;
	logic [1:0]       out_status_q;

	assign off_now  = free_address - heap_base_q;
	assign run_next = run_bytes_q + BANK_OFF;
	assign cur_next = cur_off_q + BANK_OFF;

	always_comb begin
		if (cmd.load) begin
			idx_d = '0;
		end else if (cmd.jump) begin
			idx_d = start_idx_q;
		end else if (cmd.step) begin
			idx_d = idx_q + IDX_W'(1);
		end else begin
			idx_d = idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				heap_base_q <= cfg_wr_data;
			end
			idx_q <= idx_d;
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bytes_q     <= request_bytes;
			offset_q    <= off_now;
			cur_off_q   <= '0;
			run_bytes_q <= '0;
			start_idx_q <= '0;
			start_off_q <= '0;
		end else begin
			if (cmd.step) begin
				cur_off_q <= cur_next;
			end
			if (cmd.scan) begin
				if (ram_rdata.used) begin
					run_bytes_q <= '0;
					start_idx_q <= idx_q + IDX_W'(1);
					start_off_q <= cur_next;
				end else begin
					run_bytes_q <= run_next;
				end
			end
		end
		if (cmd.jump) begin
			end_idx_q <= idx_q;
		end
		if (cmd.set_res) begin
			res_status_q <= cmd.res_code;
			res_addr_q   <= cmd.res_addr ? heap_base_q + 32'(start_off_q) : '0;
		end
		if (cmd.push) begin
			out_addr_q   <= res_addr_q;
			out_status_q <= res_status_q;
		end
	end

	assign ram_we          = cmd.we;
	assign ram_waddr       = idx_q;
	assign ram_raddr       = idx_d;
	assign ram_wdata.used  = cmd.wr_mark;
	assign ram_wdata.first = cmd.wr_mark && (idx_q == start_idx_q);
	assign ram_wdata.cont  = cmd.wr_mark && (idx_q != end_idx_q);

	assign stat.is_free      = (opcode == OP_FREE);
	assign stat.zero_bytes   = (request_bytes == '0);
	assign stat.out_of_range = (off_now >= HEAP_BYTES);
	assign stat.used         = ram_rdata.used;
	assign stat.first        = ram_rdata.first;
	assign stat.cont         = ram_rdata.cont;
	assign stat.alloc_hit    = !ram_rdata.used && (32'(run_next) >= bytes_q);
	assign stat.find_hit     = (offset_q < 32'(cur_next));
	assign stat.last_idx     = (idx_q == LAST_IDX);
	assign stat.at_end       = (idx_q == end_idx_q);
	assign stat.out_full     = out_valid_q && out_stall;

	assign out_valid        = out_valid_q;
	assign returned_address = out_addr_q;
	assign status           = out_status_q;

endmodule

`default_nettype wire

// File: sv/first_fit_bank_allocator.sv
// First-fit allocator over NUM_BANKS banks of BANK_BYTES bytes each, bank zero at heap_base.
// An allocate transaction rounds its byte count up to whole banks, claims the lowest run of
// that many free banks and returns its address with status ok, or address zero with status
// no space; a free transaction releases the run that starts at the given bank, or reports
// status invalid. After reset the block clears the mark of every bank before it takes the
// first transaction. The marks live in one memory read one bank per cycle. An allocate scans
// up from bank zero until a run fits and then marks that run; a free steps up to its bank and
// clears its run; a zero-byte allocate or an out-of-heap free goes straight to the result.
// One transaction is in progress at a time; the result register lets the next transaction
// start while the previous result waits on out_stall.
`default_nettype none

module first_fit_bank_allocator import ffba_pkg::*; #(
	parameter int BANK_BYTES = 64,
	parameter int NUM_BANKS  = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        opcode,
	input  wire logic [31:0] request_bytes,
	input  wire logic [31:0] free_address,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      returned_address,
	output logic [1:0]       status
);

	localparam int IDX_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;

	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [IDX_W-1:0] ram_raddr;
	bank_mark_t       ram_wdata;
	bank_mark_t       ram_rdata;

	ffba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	ffba_dp #(
		.BANK_BYTES (BANK_BYTES),
		.NUM_BANKS  (NUM_BANKS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.opcode           (opcode),
		.request_bytes    (request_bytes),
		.free_address     (free_address),
		.out_stall        (out_stall),
		.cmd              (cmd),
		.stat             (stat),
		.out_valid        (out_valid),
		.returned_address (returned_address),
		.status           (status),
		.ram_we           (ram_we),
		.ram_waddr        (ram_waddr),
		.ram_wdata        (ram_wdata),
		.ram_raddr        (ram_raddr),
		.ram_rdata        (ram_rdata)
	);

	ffba_ram #(
		.WIDTH ($bits(bank_mark_t)),
		.DEPTH (NUM_BANKS)
	) u_marks (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_INVALID || status == ST_NO_SPACE))
		else $error("result carries an undefined status code");

	a_fail_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> returned_address == 32'd0)
		else $error("failed transaction returned a nonzero address");

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> in_stall)
		else $error("mark memory written while accepting a transaction");

	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ram_waddr <= IDX_W'(NUM_BANKS - 1))
		else $error("mark memory written beyond the last bank");

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import ffba_pkg::*;

	localparam int BANK_BYTES = 64;
	localparam int NUM_BANKS  = 128;
	localparam int HEAP_BYTES = BANK_BYTES * NUM_BANKS;

	typedef struct {
		logic        op;
		logic [31:0] bytes;
		logic [31:0] addr;
	} heap_req_t;

	typedef struct {
		logic [31:0] addr;
		logic [1:0]  code;
	} heap_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        opcode = OP_ALLOC;
	logic [31:0] request_bytes = '0;
	logic [31:0] free_address = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] returned_address;
	logic [1:0]  status;

	heap_req_t   request_queue[$];
	heap_reply_t reply_queue[$];
	int unsigned live_banks[$];
	bank_mark_t  heap_marks [NUM_BANKS];
	logic [31:0] heap_base_model = '0;
	heap_req_t   next_req;
	bit          idle_on = 1'b1;
	int          send_gap = 0;
	int          hold_gap = 0;
	int          errors = 0;
	int          grants = 0;
	int          refusals = 0;
	int          releases = 0;
	int          rejects = 0;
	int          base_settings = 0;

	first_fit_bank_allocator #(
		.BANK_BYTES(BANK_BYTES),
		.NUM_BANKS (NUM_BANKS)
	) u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.opcode          (opcode),
		.request_bytes   (request_bytes),
		.free_address    (free_address),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.returned_address(returned_address),
		.status          (status)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic heap_reply_t compute_reply(input logic op, input logic [31:0] bytes,
			input logic [31:0] addr);
		heap_reply_t rep;
		logic [32:0] need;
		logic [31:0] offset;
		int unsigned bank;
		int run;
		int found;
		bit hit;
		rep.addr = '0;
		if (op == OP_ALLOC) begin
			rep.code = ST_NO_SPACE;
			if (bytes != 0) begin
				need = ({1'b0, bytes} + 33'(BANK_BYTES - 1)) / BANK_BYTES;
				if (need <= NUM_BANKS) begin
					run = 0;
					hit = 1'b0;
					found = 0;
					for (int i = 0; i < NUM_BANKS && !hit; i++) begin
						if (heap_marks[i].used)
							run = 0;
						else
							run++;
						if (run == need) begin
							found = i + 1 - run;
							hit = 1'b1;
						end
					end
					if (hit) begin
						heap_marks[found].first = 1'b1;
						for (int i = found; i < found + run; i++) begin
							heap_marks[i].used = 1'b1;
							heap_marks[i].cont = 1'b1;
						end
						heap_marks[found + run - 1].cont = 1'b0;
						rep.addr = heap_base_model + 32'(found * BANK_BYTES);
						rep.code = ST_OK;
						live_banks.push_back(found);
					end
				end
			end
			if (rep.code == ST_OK)
				grants++;
			else
				refusals++;
		end else begin
			rep.code = ST_INVALID;
			offset = addr - heap_base_model;
			bank = offset / BANK_BYTES;
			if (bank < NUM_BANKS && heap_marks[bank].used && heap_marks[bank].first) begin
				foreach (live_banks[k]) begin
					if (live_banks[k] == bank) begin
						live_banks.delete(k);
						break;
					end
				end
				heap_marks[bank].first = 1'b0;
				while (heap_marks[bank].cont && bank + 1 < NUM_BANKS) begin
					heap_marks[bank].used = 1'b0;
					heap_marks[bank].cont = 1'b0;
					bank++;
				end
				heap_marks[bank].used = 1'b0;
				heap_marks[bank].cont = 1'b0;
				rep.code = ST_OK;
				releases++;
			end else begin
				rejects++;
			end
		end
		return rep;
	endfunction

	function automatic heap_req_t random_request();
		heap_req_t req;
		int pick;
		int unsigned bank;
		req.op = OP_ALLOC;
		req.bytes = $urandom;
		req.addr = $urandom;
		pick = $urandom_range(0, 99);
		if (pick >= 50 && pick < 90 && live_banks.size() != 0) begin
			bank = live_banks[$urandom_range(0, live_banks.size() - 1)];
			req.op = OP_FREE;
			req.addr = heap_base_model + 32'(bank * BANK_BYTES);
			if ($urandom_range(0, 3) == 0)
				req.addr = req.addr + $urandom_range(1, BANK_BYTES - 1);
		end else if (pick >= 90) begin
			req.op = OP_FREE;
			case ($urandom_range(0, 3))
				0: req.addr = heap_base_model + $urandom_range(0, HEAP_BYTES - 1);
				1: req.addr = heap_base_model - $urandom_range(1, BANK_BYTES);
				2: req.addr = heap_base_model + HEAP_BYTES + $urandom_range(0, BANK_BYTES);
				default: req.addr = $urandom;
			endcase
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 60)
				req.bytes = $urandom_range(1, 4 * BANK_BYTES);
			else if (pick < 80)
				req.bytes = $urandom_range(1, 16 * BANK_BYTES);
			else if (pick < 88)
				req.bytes = $urandom_range(1, HEAP_BYTES);
			else if (pick < 92)
				req.bytes = $urandom_range(1, 8) * BANK_BYTES;
			else if (pick < 95)
				req.bytes = $urandom;
			else if (pick < 97)
				req.bytes = '0;
			else
				req.bytes = HEAP_BYTES + $urandom_range(0, 2 * BANK_BYTES);
		end
		return req;
	endfunction

	task automatic queue_request(input logic op, input logic [31:0] bytes,
			input logic [31:0] addr);
		heap_req_t req;
		req.op = op;
		req.bytes = bytes;
		req.addr = addr;
		request_queue.push_back(req);
	endtask

	task automatic wait_quiet();
		@(negedge clk);
		while (request_queue.size() != 0 || in_valid || reply_queue.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_heap_base(input logic [31:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		heap_base_model = value;
		base_settings++;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_phase(input logic [31:0] base, input int count, input bit idling);
		idle_on = idling;
		write_heap_base(base);
		for (int n = 0; n < count; n++) begin
			@(negedge clk);
			while (request_queue.size() >= 2)
				@(negedge clk);
			request_queue.push_back(random_request());
		end
		wait_quiet();
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				reply_queue.push_back(compute_reply(opcode, request_bytes, free_address));
			end
			if (!in_valid || !in_stall) begin
				if (send_gap != 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (request_queue.size() != 0 && idle_on && $urandom_range(0, 5) == 0) begin
					send_gap = $urandom_range(0, 18);
					in_valid <= 1'b0;
				end else if (request_queue.size() != 0) begin
					next_req = request_queue.pop_front();
					in_valid <= 1'b1;
					opcode <= next_req.op;
					request_bytes <= next_req.bytes;
					free_address <= next_req.addr;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		heap_reply_t exp_rep;
		if (arst_n && out_valid && !out_stall) begin
			if (reply_queue.size() == 0) begin
				$display("%0t: unexpected reply, expected none, got address %h status %0d",
					$time, returned_address, status);
				errors++;
			end else begin
				exp_rep = reply_queue.pop_front();
				if (returned_address !== exp_rep.addr) begin
					$display("%0t: returned_address expected %h actual %h",
						$time, exp_rep.addr, returned_address);
					errors++;
				end
				if (status !== exp_rep.code) begin
					$display("%0t: status expected %0d actual %0d", $time, exp_rep.code, status);
					errors++;
				end
			end
		end
		if (hold_gap != 0) begin
			hold_gap--;
			out_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			hold_gap = $urandom_range(0, 18);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin
		for (int i = 0; i < NUM_BANKS; i++)
			heap_marks[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		queue_request(OP_ALLOC, 32'd0, $urandom);
		queue_request(OP_ALLOC, 32'd1, $urandom);
		queue_request(OP_ALLOC, 32'd64, $urandom);
		queue_request(OP_ALLOC, 32'd65, $urandom);
		queue_request(OP_ALLOC, 32'hFFFF_FFFF, $urandom);
		queue_request(OP_ALLOC, HEAP_BYTES + 1, $urandom);
		queue_request(OP_FREE, $urandom, 32'd192);
		queue_request(OP_FREE, $urandom, 32'd133);
		queue_request(OP_FREE, $urandom, 32'd128);
		queue_request(OP_FREE, $urandom, 32'hFFFF_FFFF);
		queue_request(OP_FREE, $urandom, HEAP_BYTES);
		queue_request(OP_FREE, $urandom, 32'd64);
		queue_request(OP_ALLOC, 32'd128, $urandom);
		queue_request(OP_FREE, $urandom, 32'd0);
		queue_request(OP_FREE, $urandom, 32'd64);
		queue_request(OP_ALLOC, HEAP_BYTES, $urandom);
		queue_request(OP_ALLOC, 32'd1, $urandom);
		queue_request(OP_FREE, $urandom, HEAP_BYTES - 1);
		queue_request(OP_FREE, $urandom, 32'd0);
		queue_request(OP_ALLOC, HEAP_BYTES - BANK_BYTES, $urandom);
		queue_request(OP_ALLOC, 32'd64, $urandom);
		queue_request(OP_FREE, $urandom, HEAP_BYTES - BANK_BYTES);
		queue_request(OP_FREE, $urandom, 32'd0);
		queue_request(OP_ALLOC, 32'hFFFF_FFC0, $urandom);
		wait_quiet();

		run_phase(32'h0000_1000, 250, 1'b1);
		run_phase(32'hFFFF_FFFF, 250, 1'b1);
		run_phase($urandom, 200, 1'b1);
		run_phase(32'hFFFF_E000, 200, 1'b1);
		run_phase(32'h0000_0000, 300, 1'b0);

		repeat (300) @(posedge clk);
		$display("Covered %0d granted and %0d refused allocations, %0d released and %0d rejected frees,",
			grants, refusals, releases, rejects);
		$display("across %0d written heap base values after the reset value.", base_settings);
		if (errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Run did not drain in time.");
		$display("testbench failed");
		$finish;
	end

endmodule
